>>> hw/rtl/sbed_pkg.sv
// Shared types and constants for the steering button event decoder.
package sbed_pkg;

    localparam logic [15:0] BUS_MIN_INVALID = 16'h0006;
    localparam logic [15:0] BUS_IDLE_WORD   = 16'h001F;

    localparam logic [15:0] LONG_PRESS_RESET = 16'd50;
    localparam logic [7:0]  DEMO_HOLD_RESET  = 8'd100;

    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEMO_HOLD  = 1'b1;

    localparam logic [1:0] CMD_NONE       = 2'd0;
    localparam logic [1:0] CRUISE_ENABLE  = 2'd1;
    localparam logic [1:0] CRUISE_DISABLE = 2'd2;
    localparam logic [1:0] FLASH_OFF      = 2'd1;
    localparam logic [1:0] FLASH_ON       = 2'd2;
    localparam logic [1:0] LAMP_ON        = 2'd1;
    localparam logic [1:0] LAMP_OFF       = 2'd2;

    typedef struct packed {
        logic [15:0] bus_value;
        logic        right_pad;
        logic        left_pad;
        logic        cruise_on;
        logic        special_flash_busy;
    } sbed_in_t;

    typedef struct packed {
        logic [1:0] cruise_cmd;
        logic       step_up;
        logic       accel_hold;
        logic       accel_release;
        logic       step_down;
        logic       decel_hold;
        logic       decel_release;
        logic [1:0] right_cmd;
        logic [1:0] left_cmd;
        logic [1:0] hazard_cmd;
        logic [1:0] lamp_cmd;
        logic       demo_on;
    } sbed_out_t;

    typedef struct packed {
        logic step;
        logic hold;
        logic rel;
    } sbed_key_pulse_t;

endpackage

>>> hw/rtl/sbed_key.sv
// Up/down key tracker: arm, single step, long-press count, hold and release pulses.
module sbed_key (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    level,
    input  logic [15:0]             limit,
    output sbed_pkg::sbed_key_pulse_t pulse
);

    logic        armed_reg, armed_next;
    logic        active_reg, active_next;
    logic [15:0] count_reg, count_next;

    always_comb begin
        armed_next  = armed_reg;
        active_next = active_reg;
        count_next  = count_reg;
        pulse       = '0;
        if (!level && armed_reg) begin
            pulse.step = 1'b1;
            armed_next = 1'b0;
        end else if (!level) begin
            count_next = count_reg + 16'd1;
            if (count_next > limit) begin
                pulse.hold  = 1'b1;
                active_next = 1'b1;
            end
        end else begin
            if (active_reg) begin
                active_next = 1'b0;
                pulse.rel   = 1'b1;
            end
            armed_next = 1'b1;
            count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg  <= 1'b0;
            active_reg <= 1'b0;
            count_reg  <= '0;
        end else if (en) begin
            armed_reg  <= armed_next;
            active_reg <= active_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hw/rtl/sbed_core.sv
// Decoder state and per-word event logic: key latch, up/down keys, cruise, pads, lamp, demo.
module sbed_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  sbed_pkg::sbed_in_t  in_word,
    input  logic [15:0]         long_press_ticks,
    input  logic [7:0]          demo_hold_ticks,
    output sbed_pkg::sbed_out_t out_word
);

    logic [3:0] keys_reg, keys_next;
    logic       cruise_armed_reg, cruise_armed_next;
    logic       right_armed_reg, right_armed_next;
    logic       left_armed_reg, left_armed_next;
    logic       hazard_armed_reg, hazard_armed_next;
    logic       right_active_reg, right_active_next;
    logic       left_active_reg, left_active_next;
    logic       hazard_active_reg, hazard_active_next;
    logic       lamp_armed_reg, lamp_armed_next;
    logic [7:0] lamp_count_reg, lamp_count_next;

    logic rp, lp;
    sbed_pkg::sbed_key_pulse_t up_pulse, down_pulse;

    assign rp = in_word.right_pad;
    assign lp = in_word.left_pad;

    always_comb begin
        keys_next = keys_reg;
        if (in_word.bus_value > sbed_pkg::BUS_MIN_INVALID &&
            in_word.bus_value != sbed_pkg::BUS_IDLE_WORD) begin
            keys_next = {in_word.bus_value[7], in_word.bus_value[4],
                         in_word.bus_value[3], in_word.bus_value[2]};
        end
    end

    sbed_key u_up (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .level   (keys_next[1]),
        .limit   (long_press_ticks),
        .pulse   (up_pulse)
    );

    sbed_key u_down (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .level   (keys_next[0]),
        .limit   (long_press_ticks),
        .pulse   (down_pulse)
    );

    always_comb begin
        out_word           = '0;
        cruise_armed_next  = cruise_armed_reg;
        right_armed_next   = right_armed_reg;
        left_armed_next    = left_armed_reg;
        hazard_armed_next  = hazard_armed_reg;
        right_active_next  = right_active_reg;
        left_active_next   = left_active_reg;
        hazard_active_next = hazard_active_reg;
        lamp_armed_next    = lamp_armed_reg;
        lamp_count_next    = lamp_count_reg;

        out_word.step_up       = up_pulse.step;
        out_word.accel_hold    = up_pulse.hold;
        out_word.accel_release = up_pulse.rel;
        out_word.step_down     = down_pulse.step;
        out_word.decel_hold    = down_pulse.hold;
        out_word.decel_release = down_pulse.rel;

        if (!keys_next[3] && cruise_armed_reg) begin
            out_word.cruise_cmd = in_word.cruise_on ? sbed_pkg::CRUISE_DISABLE
                                                    : sbed_pkg::CRUISE_ENABLE;
            cruise_armed_next   = 1'b0;
        end else if (keys_next[3]) begin
            cruise_armed_next = 1'b1;
        end

        if (!rp && right_armed_reg) begin
            right_armed_next = 1'b0;
            if (right_active_next || left_active_next || hazard_active_next) begin
                out_word.right_cmd = sbed_pkg::FLASH_OFF;
                right_active_next  = 1'b0;
                left_active_next   = 1'b0;
                hazard_active_next = 1'b0;
            end else begin
                out_word.right_cmd = sbed_pkg::FLASH_ON;
                right_active_next  = 1'b1;
            end
        end else if (rp) begin
            right_armed_next = 1'b1;
        end

        if (!lp && left_armed_reg) begin
            left_armed_next = 1'b0;
            if (left_active_next || right_active_next || hazard_active_next) begin
                out_word.left_cmd  = sbed_pkg::FLASH_OFF;
                left_active_next   = 1'b0;
                right_active_next  = 1'b0;
                hazard_active_next = 1'b0;
            end else begin
                out_word.left_cmd = sbed_pkg::FLASH_ON;
                left_active_next  = 1'b1;
            end
        end else if (lp) begin
            left_armed_next = 1'b1;
        end

        if (!lp && hazard_armed_reg) begin
            if (!rp) begin
                hazard_armed_next = 1'b0;
                if (hazard_active_next) begin
                    out_word.hazard_cmd = sbed_pkg::FLASH_OFF;
                    hazard_active_next  = 1'b0;
                end else begin
                    out_word.hazard_cmd = sbed_pkg::FLASH_ON;
                    hazard_active_next  = 1'b1;
                end
            end
        end else if (lp && rp) begin
            hazard_armed_next = 1'b1;
        end

        if (!keys_next[2]) begin
            lamp_count_next = lamp_count_reg + 8'd1;
            if (lamp_armed_reg) begin
                out_word.lamp_cmd = in_word.special_flash_busy ? sbed_pkg::LAMP_OFF
                                                               : sbed_pkg::LAMP_ON;
                lamp_armed_next   = 1'b0;
            end
            if (lamp_count_next > demo_hold_ticks) begin
                lamp_count_next  = '0;
                out_word.demo_on = 1'b1;
            end
        end else begin
            lamp_armed_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keys_reg          <= '0;
            cruise_armed_reg  <= 1'b0;
            right_armed_reg   <= 1'b0;
            left_armed_reg    <= 1'b0;
            hazard_armed_reg  <= 1'b0;
            right_active_reg  <= 1'b0;
            left_active_reg   <= 1'b0;
            hazard_active_reg <= 1'b0;
            lamp_armed_reg    <= 1'b0;
            lamp_count_reg    <= '0;
        end else if (en) begin
            keys_reg          <= keys_next;
            cruise_armed_reg  <= cruise_armed_next;
            right_armed_reg   <= right_armed_next;
            left_armed_reg    <= left_armed_next;
            hazard_armed_reg  <= hazard_armed_next;
            right_active_reg  <= right_active_next;
            left_active_reg   <= left_active_next;
            hazard_active_reg <= hazard_active_next;
            lamp_armed_reg    <= lamp_armed_next;
            lamp_count_reg    <= lamp_count_next;
        end
    end

endmodule

>>> hw/rtl/steering_button_event_decoder_top.sv
// Steering button event decoder: input register, decode core, result register.
//
// One input word per polling tick on s_valid/s_ready (sbed_in_t) carries the
// button bus word, both pad levels and two status flags. Each accepted word
// produces exactly one result word on m_valid/m_ready (sbed_out_t) with the
// command pulses for that tick; fields with nothing to report are zero.
// Each accepted word goes from the input register through the decode into the
// result register. Throughput: one word per cycle unless m_ready stalls the result;
// the input register, combinational decode and result register move together.
// When m_ready is low the result register holds, the input register fills,
// and s_ready then drops until the result is taken.
// Reset (aresetn low, synchronous) clears all key, pad and lamp state,
// empties both registers and loads long_press_ticks = 50 and
// demo_hold_ticks = 100.
// Configuration: cfg_we with cfg_index 0 writes long_press_ticks (16 bits),
// index 1 writes demo_hold_ticks (low 8 bits); write only while idle.
module steering_button_event_decoder_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  sbed_pkg::sbed_in_t                    s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output sbed_pkg::sbed_out_t                   m_data,
    input  logic                                  cfg_we,
    input  logic [sbed_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [sbed_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    logic                in_valid_reg;
    sbed_pkg::sbed_in_t  in_data_reg;
    logic                out_valid_reg;
    sbed_pkg::sbed_out_t out_data_reg;
    sbed_pkg::sbed_out_t out_data_next;
    logic [15:0]         long_press_reg;
    logic [7:0]          demo_hold_reg;
    logic                advance;
    logic                fire;

    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_press_reg <= sbed_pkg::LONG_PRESS_RESET;
            demo_hold_reg  <= sbed_pkg::DEMO_HOLD_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                sbed_pkg::CFG_LONG_PRESS: long_press_reg <= cfg_wdata;
                sbed_pkg::CFG_DEMO_HOLD:  demo_hold_reg  <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    sbed_core u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .en               (fire),
        .in_word          (in_data_reg),
        .long_press_ticks (long_press_reg),
        .demo_hold_ticks  (demo_hold_reg),
        .out_word         (out_data_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

>>> hw/rtl/sbed_checker.sv
// Port-level checks for the steering button event decoder, bound to the top level.
module sbed_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input sbed_pkg::sbed_out_t m_data
);

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid || m_ready |-> s_ready)
        else $error("input not ready while result side drains");

    a_empty_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_up_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $countones({m_data.step_up, m_data.accel_hold,
                                m_data.accel_release}) <= 1)
        else $error("conflicting up key pulses");

    a_down_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $countones({m_data.step_down, m_data.decel_hold,
                                m_data.decel_release}) <= 1)
        else $error("conflicting down key pulses");

endmodule

bind steering_button_event_decoder_top sbed_checker u_sbed_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
